/* rtl/core/qte_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

  localparam int CordicStagesDef = 16;
  localparam int FracBitsDef     = 14;
  localparam int ZW              = 36;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } qte_in_t;

  typedef struct packed {
    logic signed [14:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic               gimbal_locked;
  } qte_out_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 36'sd294912000;  1: r = 36'sd174096719;  2: r = 36'sd91987925;
      3: r = 36'sd46694507;   4: r = 36'sd23437865;   5: r = 36'sd11730358;
      6: r = 36'sd5866610;    7: r = 36'sd2933484;    8: r = 36'sd1466764;
      9: r = 36'sd733385;     10: r = 36'sd366693;    11: r = 36'sd183346;
      12: r = 36'sd91673;     13: r = 36'sd45837;     14: r = 36'sd22918;
      15: r = 36'sd11459;     16: r = 36'sd5730;      17: r = 36'sd2865;
      18: r = 36'sd1432;      19: r = 36'sd716;       20: r = 36'sd358;
      21: r = 36'sd179;       22: r = 36'sd90;        23: r = 36'sd45;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/quaternion_to_euler_degrees_core.sv */
`timescale 1ns / 1ps
// Quaternion to Euler angles in hundredths of a degree, fully pipelined.
// The result passes the matrix terms, the squares, the square-root bit stages, the lock
// test, the CORDIC rotations and the output register before it is strobed.
// Throughput: one transaction per cycle, busy is always low; results cannot be stalled.
// Reset clears all valid bits and sets the lock threshold to one.
`default_nettype none
module quaternion_to_euler_degrees_core import qte_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDef,
  parameter int FRAC_BITS     = FracBitsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire qte_in_t  data_i,
  output logic          strobe_o,
  output qte_out_t      result_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [14:0] cfg_data_i
);
  // Matrix terms span +-2.0 in FRAC_BITS fraction bits plus sign.
  localparam int MW  = FRAC_BITS + 3;
  // Squared sum reaches 2^(2*FRAC_BITS+3); keep an even width for the root.
  localparam int NW  = 2 * FRAC_BITS + 4;
  localparam int RW  = NW / 2;
  localparam int CW  = 32 + FRAC_BITS;
  // The CORDIC inputs share one width wide enough for any term or cy.
  localparam int VW  = (RW + 1 > MW + 1) ? RW + 1 : MW + 1;
  localparam int PW  = 2 * MW;

  logic [14:0] thr_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 15'd1;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // Stage group one: matrix terms.
  logic                 mv_w;
  logic signed [MW-1:0] m11_w, m12_w, m21_w, m22_w, m31_w, m32_w, m33_w;

  qte_matrix #(.FracBits(FRAC_BITS), .MW(MW)) u_matrix (
    .clk_i, .rst_ni, .valid_i(start), .quat_i(data_i), .valid_o(mv_w),
    .m11_o(m11_w), .m12_o(m12_w), .m21_o(m21_w), .m22_o(m22_w),
    .m31_o(m31_w), .m32_o(m32_w), .m33_o(m33_w)
  );

  // Squares registered before the root so the multipliers stand alone.
  logic                 sv_q;
  logic [NW-1:0]        sum_q;
  logic signed [MW-1:0] s11_q, s12_q, s21_q, s22_q, s31_q, s32_q, s33_q;
  logic signed [PW-1:0] sq31_w, sq33_w;

  assign sq31_w = PW'(m31_w) * PW'(m31_w);
  assign sq33_w = PW'(m33_w) * PW'(m33_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else begin
      sv_q <= mv_w;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= NW'(sq31_w) + NW'(sq33_w);
    s11_q <= m11_w; s12_q <= m12_w; s21_q <= m21_w; s22_q <= m22_w;
    s31_q <= m31_w; s32_q <= m32_w; s33_q <= m33_w;
  end

  // The remaining terms ride along the square-root pipeline.
  logic [7*MW-1:0] carry_w, carried_w;
  logic            rv_w;
  logic [RW-1:0]   cy_w;

  assign carry_w = {s11_q, s12_q, s21_q, s22_q, s31_q, s32_q, s33_q};

  qte_isqrt #(.NW(NW), .DW(7*MW)) u_isqrt (
    .clk_i, .rst_ni, .valid_i(sv_q), .n_i(sum_q), .data_i(carry_w),
    .valid_o(rv_w), .root_o(cy_w), .data_o(carried_w)
  );

  logic signed [MW-1:0] c11_w, c12_w, c21_w, c22_w, c31_w, c32_w, c33_w;
  assign {c11_w, c12_w, c21_w, c22_w, c31_w, c32_w, c33_w} = carried_w;

  // Lock test: cy * 2^14 against threshold * 2^FRAC_BITS, then operand choice.
  logic                 lv_q, lock_q;
  logic signed [VW-1:0] px_q, py_q, yx_q, yy_q, zx_q, zy_q;
  logic                 locked_w;

  assign locked_w = (CW'(cy_w) << 14) <= (CW'(thr_q) << FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q <= 1'b0;
    end else begin
      lv_q <= rv_w;
    end
  end

  always_ff @(posedge clk_i) begin
    lock_q <= locked_w;
    px_q   <= VW'(cy_w);
    py_q   <= -VW'(c32_w);
    yx_q   <= VW'(c33_w);
    yy_q   <= VW'(c31_w);
    if (locked_w) begin
      zx_q <= VW'(c11_w);
      zy_q <= -VW'(c21_w);
    end else begin
      zx_q <= VW'(c22_w);
      zy_q <= VW'(c12_w);
    end
  end

  // Three CORDIC pipelines run side by side; the lock flag rides with one.
  logic               av_w, bv_w, cv_w;
  logic signed [16:0] ax_w, ay_w, az_w;
  logic [0:0]         lk_w, unb_w, unc_w;

  qte_cordic #(.Stages(CORDIC_STAGES), .VW(VW), .Lim(9000), .SW(1)) u_cordic_x (
    .clk_i, .rst_ni, .valid_i(lv_q), .y_i(py_q), .x_i(px_q), .side_i(lock_q),
    .valid_o(av_w), .angle_o(ax_w), .side_o(lk_w)
  );
  qte_cordic #(.Stages(CORDIC_STAGES), .VW(VW), .Lim(18000), .SW(1)) u_cordic_y (
    .clk_i, .rst_ni, .valid_i(lv_q), .y_i(yy_q), .x_i(yx_q), .side_i(1'b0),
    .valid_o(bv_w), .angle_o(ay_w), .side_o(unb_w)
  );
  qte_cordic #(.Stages(CORDIC_STAGES), .VW(VW), .Lim(18000), .SW(1)) u_cordic_z (
    .clk_i, .rst_ni, .valid_i(lv_q), .y_i(zy_q), .x_i(zx_q), .side_i(1'b0),
    .valid_o(cv_w), .angle_o(az_w), .side_o(unc_w)
  );

  // Output register: the second angle is forced to zero under gimbal lock.
  logic     ov_q;
  qte_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= av_w & bv_w & cv_w & ~(unb_w[0] & unc_w[0]);
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.angle_x       <= ax_w[14:0];
    out_q.angle_y       <= lk_w[0] ? 16'sd0 : ay_w[15:0];
    out_q.angle_z       <= az_w[15:0];
    out_q.gimbal_locked <= lk_w[0];
  end

  assign strobe_o = ov_q;
  assign result_o = out_q;
endmodule
`default_nettype wire

/* rtl/core/qte_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipelined vectoring CORDIC, one rotation per register stage.
module qte_cordic import qte_pkg::*; #(
  parameter int Stages = CordicStagesDef,
  parameter int VW     = 24,
  parameter int Lim    = 18000,
  parameter int SW     = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic signed [VW-1:0] y_i,
  input  wire logic signed [VW-1:0] x_i,
  input  wire logic [SW-1:0]        side_i,
  output logic                      valid_o,
  output logic signed [16:0]        angle_o,
  output logic [SW-1:0]             side_o
);
  localparam int XW = VW + 2;
  localparam int Ns = (Stages < 24) ? Stages : 24;

  logic [Ns:0]                 v_q;
  logic [Ns:0]                 zr_q;
  logic signed [XW-1:0]        x_q [Ns+1];
  logic signed [XW-1:0]        y_q [Ns+1];
  logic signed [ZW-1:0]        z_q [Ns+1];
  logic [SW-1:0]               s_q [Ns+2];
  logic                        v2_q;
  logic signed [16:0]          a_q;

  // Entry stage: zero vector and left half-plane handling.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q[0]  <= side_i;
    zr_q[0] <= (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      x_q[0] <= -XW'(x_i);
      y_q[0] <= -XW'(y_i);
      z_q[0] <= (y_i >= 0) ? ZW'(64'sd1179648000) : -ZW'(64'sd1179648000);
    end else begin
      x_q[0] <= XW'(x_i);
      y_q[0] <= XW'(y_i);
      z_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < Ns; i++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      s_q[i+1]  <= s_q[i];
      zr_q[i+1] <= zr_q[i];
      if (y_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + atan_entry(i);
      end else begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - atan_entry(i);
      end
    end
  end

  // Round to hundredths and clamp. A zero vector gives a zero angle.
  logic signed [ZW-1:0] r_w;
  assign r_w = (z_q[Ns] + ZW'(32768)) >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v_q[Ns];
    end
  end

  always_ff @(posedge clk_i) begin
    s_q[Ns+1] <= s_q[Ns];
    if (zr_q[Ns])             a_q <= '0;
    else if (r_w > ZW'(Lim))  a_q <= 17'(Lim);
    else if (r_w < -ZW'(Lim)) a_q <= -17'(Lim);
    else                      a_q <= r_w[16:0];
  end

  assign valid_o = v2_q;
  assign angle_o = a_q;
  assign side_o  = s_q[Ns+1];
endmodule
`default_nettype wire

/* rtl/core/qte_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring square root, one result bit per stage.
module qte_isqrt import qte_pkg::*; #(
  parameter int NW = 36,
  parameter int DW = 24
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] n_i,
  input  wire logic [DW-1:0] data_i,
  output logic               valid_o,
  output logic [NW/2-1:0]    root_o,
  output logic [DW-1:0]      data_o
);
  localparam int RW = NW / 2;

  logic [RW:0]     v_q;
  logic [NW-1:0]   n_q [RW+1];
  logic [NW-1:0]   r_q [RW+1];
  logic [DW-1:0]   d_q [RW+1];

  assign v_q[0] = valid_i;
  assign n_q[0] = n_i;
  assign r_q[0] = '0;
  assign d_q[0] = data_i;

  for (genvar k = 0; k < RW; k++) begin : g_bit
    localparam logic [NW-1:0] Bit = NW'(1) << (NW - 2 - 2 * k);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      d_q[k+1] <= d_q[k];
      if (n_q[k] >= r_q[k] + Bit) begin
        n_q[k+1] <= n_q[k] - (r_q[k] + Bit);
        r_q[k+1] <= (r_q[k] >> 1) + Bit;
      end else begin
        n_q[k+1] <= n_q[k];
        r_q[k+1] <= r_q[k] >> 1;
      end
    end
  end

  assign valid_o = v_q[RW];
  assign root_o  = r_q[RW][RW-1:0];
  assign data_o  = d_q[RW];
endmodule
`default_nettype wire

/* rtl/core/qte_matrix.sv */
`timescale 1ns / 1ps
`default_nettype none
// Rotation matrix terms: products, then scaling and saturation.
module qte_matrix import qte_pkg::*; #(
  parameter int FracBits = FracBitsDef,
  parameter int MW       = FracBits + 3
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire qte_in_t              quat_i,
  output logic                      valid_o,
  output logic signed [MW-1:0]      m11_o,
  output logic signed [MW-1:0]      m12_o,
  output logic signed [MW-1:0]      m21_o,
  output logic signed [MW-1:0]      m22_o,
  output logic signed [MW-1:0]      m31_o,
  output logic signed [MW-1:0]      m32_o,
  output logic signed [MW-1:0]      m33_o
);
  localparam int PW = 40;
  localparam int Sh = 28 - FracBits;
  localparam int EW = PW + ((Sh < 0) ? -Sh : 0);

  logic signed [31:0] xx_q, yy_q, zz_q, xy_q, xz_q, xw_q, yz_q, yw_q, zw_q;
  logic               v1_q, v2_q;
  logic signed [MW-1:0] m_q [7];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xx_q <= quat_i.quat_x * quat_i.quat_x;
    yy_q <= quat_i.quat_y * quat_i.quat_y;
    zz_q <= quat_i.quat_z * quat_i.quat_z;
    xy_q <= quat_i.quat_x * quat_i.quat_y;
    xz_q <= quat_i.quat_x * quat_i.quat_z;
    xw_q <= quat_i.quat_x * quat_i.quat_w;
    yz_q <= quat_i.quat_y * quat_i.quat_z;
    yw_q <= quat_i.quat_y * quat_i.quat_w;
    zw_q <= quat_i.quat_z * quat_i.quat_w;
  end

  function automatic logic signed [MW-1:0] to_frac(input logic signed [PW-1:0] v);
    logic signed [EW-1:0] t;
    logic signed [EW-1:0] lim;
    lim = EW'(1) <<< (FracBits + 1);
    if (Sh > 0) t = (EW'(v) + (EW'(1) <<< (Sh - 1))) >>> Sh;
    else        t = EW'(v) <<< ((Sh < 0) ? -Sh : 0);
    if (t > lim)       t = lim;
    else if (t < -lim) t = -lim;
    return t[MW-1:0];
  endfunction

  logic signed [PW-1:0] one_w;
  assign one_w = PW'(1) <<< 28;

  always_ff @(posedge clk_i) begin
    m_q[0] <= to_frac(one_w - 2 * (PW'(yy_q) + PW'(zz_q)));
    m_q[1] <= to_frac(2 * (PW'(xy_q) + PW'(zw_q)));
    m_q[2] <= to_frac(2 * (PW'(xy_q) - PW'(zw_q)));
    m_q[3] <= to_frac(one_w - 2 * (PW'(xx_q) + PW'(zz_q)));
    m_q[4] <= to_frac(2 * (PW'(xz_q) + PW'(yw_q)));
    m_q[5] <= to_frac(2 * (PW'(yz_q) - PW'(xw_q)));
    m_q[6] <= to_frac(one_w - 2 * (PW'(xx_q) + PW'(yy_q)));
  end

  assign valid_o = v2_q;
  assign m11_o = m_q[0];
  assign m12_o = m_q[1];
  assign m21_o = m_q[2];
  assign m22_o = m_q[3];
  assign m31_o = m_q[4];
  assign m32_o = m_q[5];
  assign m33_o = m_q[6];
endmodule
`default_nettype wire
